### rtl/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg
// shared constants and register index codes for the saturation region finder
// ----------------------------------------------------------------------------
package srf_pkg;

    // gap counter and rollback register width
    localparam int GAP_BITS       = 16;
    localparam logic [GAP_BITS-1:0] GAP_MAX = {GAP_BITS{1'b1}};

    // config write data covers the widest register
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    // register reset values
    localparam int SAT_CODE_RESET = 4095;
    localparam logic [GAP_BITS-1:0] ROLLBACK_RESET = 16'd10;

    // register index codes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SAT_CODE     = 1'b0,
        REG_MAX_ROLLBACK = 1'b1
    } srf_reg_idx_t;

endpackage

### rtl/srf_if.sv
// ----------------------------------------------------------------------------
// srf_if
// valid/ready channels for the sample stream and the region report stream
// ----------------------------------------------------------------------------
interface srf_sample_if #(
    parameter int CODE_BITS = 12
);
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] sample_code;
    logic                 end_of_record;

    modport source (output valid, output sample_code, output end_of_record, input ready);
    modport sink   (input valid, input sample_code, input end_of_record, output ready);
endinterface

interface srf_region_if #(
    parameter int INDEX_BITS = 20
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] region_first;
    logic [INDEX_BITS-1:0] region_final;

    modport source (output valid, output region_first, output region_final, input ready);
    modport sink   (input valid, input region_first, input region_final, output ready);
endinterface

### rtl/srf_region_tracker.sv
// ----------------------------------------------------------------------------
// srf_region_tracker
// config registers, saturation compare and region state update per item
// ----------------------------------------------------------------------------
module srf_region_tracker
    import srf_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int CODE_BITS  = 12
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      step,
    input  logic [CODE_BITS-1:0]      sample_code,
    input  logic                      end_of_record,
    output logic                      report,
    output logic [INDEX_BITS-1:0]     report_first,
    output logic [INDEX_BITS-1:0]     report_final
);

    logic [CODE_BITS-1:0]  sat_code_reg;
    logic [GAP_BITS-1:0]   rollback_reg;
    logic                  in_region_reg, in_region_next;
    logic [GAP_BITS-1:0]   gap_count_reg, gap_count_next;
    logic [INDEX_BITS-1:0] open_first_reg, open_first_next;
    logic [INDEX_BITS-1:0] open_final_reg, open_final_next;
    logic [INDEX_BITS-1:0] sample_index_reg, sample_index_next;
    logic                  saturated;
    logic                  closed;
    logic [GAP_BITS-1:0]   gap_inc;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_code_reg <= CODE_BITS'(SAT_CODE_RESET);
            rollback_reg <= ROLLBACK_RESET;
        end
        else if (cfg_en)
        begin
            case (srf_reg_idx_t'(cfg_index))
                REG_SAT_CODE:     sat_code_reg <= cfg_data[CODE_BITS-1:0];
                REG_MAX_ROLLBACK: rollback_reg <= cfg_data[GAP_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign saturated = sample_code >= sat_code_reg;
    assign gap_inc   = (gap_count_reg == GAP_MAX) ? GAP_MAX : gap_count_reg + 1'b1;

    always_comb
    begin
        in_region_next    = in_region_reg;
        gap_count_next    = gap_count_reg;
        open_first_next   = open_first_reg;
        open_final_next   = open_final_reg;
        closed            = 1'b0;
        if (in_region_reg)
        begin
            if (saturated)
            begin
                gap_count_next  = '0;
                open_final_next = sample_index_reg;
            end
            else
            begin
                gap_count_next = gap_inc;
                if (gap_inc >= rollback_reg)
                begin
                    closed         = 1'b1;
                    in_region_next = 1'b0;
                end
            end
        end
        else if (saturated)
        begin
            open_first_next = sample_index_reg;
            open_final_next = sample_index_reg;
            gap_count_next  = '0;
            in_region_next  = 1'b1;
        end

        report       = step && (closed || (end_of_record && in_region_next));
        report_first = open_first_next;
        report_final = open_final_next;

        if (end_of_record)
        begin
            in_region_next    = 1'b0;
            gap_count_next    = '0;
            sample_index_next = '0;
        end
        else
        begin
            sample_index_next = sample_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_region_reg    <= 1'b0;
            gap_count_reg    <= '0;
            open_first_reg   <= '0;
            open_final_reg   <= '0;
            sample_index_reg <= '0;
        end
        else if (step)
        begin
            in_region_reg    <= in_region_next;
            gap_count_reg    <= gap_count_next;
            open_first_reg   <= open_first_next;
            open_final_reg   <= open_final_next;
            sample_index_reg <= sample_index_next;
        end
    end

endmodule

### rtl/srf_out_stage.sv
// ----------------------------------------------------------------------------
// srf_out_stage
// result register with one skid entry behind it
// ----------------------------------------------------------------------------
module srf_out_stage #(
    parameter int INDEX_BITS = 20
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [INDEX_BITS-1:0] push_first,
    input  logic [INDEX_BITS-1:0] push_final,
    output logic                  space,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [INDEX_BITS-1:0] out_first,
    output logic [INDEX_BITS-1:0] out_final
);

    logic                  main_valid_reg;
    logic [INDEX_BITS-1:0] main_first_reg, main_final_reg;
    logic                  skid_valid_reg;
    logic [INDEX_BITS-1:0] skid_first_reg, skid_final_reg;
    logic                  main_take;

    assign main_take = !main_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_take)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_take)
        begin
            main_first_reg <= skid_valid_reg ? skid_first_reg : push_first;
            main_final_reg <= skid_valid_reg ? skid_final_reg : push_final;
        end
        else if (push)
        begin
            skid_first_reg <= push_first;
            skid_final_reg <= push_final;
        end
    end

    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_first = main_first_reg;
    assign out_final = main_final_reg;

endmodule

### rtl/saturation_region_finder_core.sv
// ----------------------------------------------------------------------------
// saturation_region_finder_core
// finds runs of saturated adc samples and reports each closed run
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                          taken when
//  samples   in    sample_code, end_of_record       valid && ready
//  regions   out   region_first, region_final       valid && ready
//  cfg       in    cfg_index, cfg_data              cfg_en
//
//  one item per cycle while the skid entry is free: the compare and state
//  update sit between the region state registers and the result register
//  a region report enters the result register, or the skid entry while it is held
//  samples.ready drops only while both the result register and the skid
//  entry hold reports, and stays low until the sink takes the result register
//  rst_n clears state, the index counter and the output valids; config
//  registers return to saturation code all ones and rollback 10
//
module saturation_region_finder_core
    import srf_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int CODE_BITS  = 12
)(
    input  logic                      clk,
    input  logic                      rst_n,
    srf_sample_if.sink                samples,
    srf_region_if.source              regions,
    input  logic                      cfg_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic                  space;
    logic                  step;
    logic                  report;
    logic [INDEX_BITS-1:0] report_first;
    logic [INDEX_BITS-1:0] report_final;

    // an item is taken whenever the skid entry is free
    assign samples.ready = space;
    assign step          = samples.valid && space;

    // per-item region tracking
    srf_region_tracker #(
        .INDEX_BITS (INDEX_BITS),
        .CODE_BITS  (CODE_BITS)
    ) u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_en        (cfg_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .step          (step),
        .sample_code   (samples.sample_code),
        .end_of_record (samples.end_of_record),
        .report        (report),
        .report_first  (report_first),
        .report_final  (report_final)
    );

    // result register plus skid
    srf_out_stage #(
        .INDEX_BITS (INDEX_BITS)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (report),
        .push_first (report_first),
        .push_final (report_final),
        .space      (space),
        .out_valid  (regions.valid),
        .out_ready  (regions.ready),
        .out_first  (regions.region_first),
        .out_final  (regions.region_final)
    );

endmodule

### rtl/srf_checker.sv
// ----------------------------------------------------------------------------
// srf_checker
// port-level checks on the saturation region finder
// ----------------------------------------------------------------------------
module srf_checker #(
    parameter int INDEX_BITS = 20,
    parameter int CODE_BITS  = 12
)(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [CODE_BITS-1:0]  sample_code,
    input logic                  end_of_record,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [INDEX_BITS-1:0] region_first,
    input logic [INDEX_BITS-1:0] region_final
);

    // stalled report holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(region_first)
            && $stable(region_final))
        else $error("stalled region report changed");

    // backpressure only with a report already waiting
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending report");

    // full-scale last sample always closes a region
    a_eor_report: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_record && (&sample_code) |=> out_valid)
        else $error("saturated end of record gave no report");

endmodule

bind saturation_region_finder_core srf_checker #(
    .INDEX_BITS (INDEX_BITS),
    .CODE_BITS  (CODE_BITS)
) u_srf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .sample_code   (samples.sample_code),
    .end_of_record (samples.end_of_record),
    .out_valid     (regions.valid),
    .out_ready     (regions.ready),
    .region_first  (regions.region_first),
    .region_final  (regions.region_final)
);

### verif/srf_region_checker.sv
// ----------------------------------------------------------------------------
// srf_region_checker
// watches the sample, region and config ports of the saturation region
// finder, tracks the open region itself and compares every reported region
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module srf_region_checker
    import srf_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int CODE_BITS  = 12
)(
    input  logic                      clk,
    input  logic                      rst_n,
    srf_sample_if                     samples,
    srf_region_if                     regions,
    input  logic                      cfg_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        fail_count,
    output int                        pending,
    output int                        regions_checked
);

    typedef struct packed {
        logic [INDEX_BITS-1:0] span_first;
        logic [INDEX_BITS-1:0] span_last;
    } region_span_t;

    // register copies
    logic [CODE_BITS-1:0]  thr_code;
    logic [GAP_BITS-1:0]   rollback;

    // tracker state
    logic                  in_region;
    logic [GAP_BITS-1:0]   gap_count;
    logic [INDEX_BITS-1:0] open_first;
    logic [INDEX_BITS-1:0] open_final;
    logic [INDEX_BITS-1:0] sample_idx;

    region_span_t          expected_regions[$];
    int                    errors;
    int                    checked;

    // one sample through the region tracker, queueing the region it closes
    task automatic track_sample(input logic [CODE_BITS-1:0] code, input logic last);
        logic         saturated;
        logic         close_now;
        region_span_t span;
        saturated = (code >= thr_code);
        close_now = 1'b0;
        if (in_region)
        begin
            if (saturated)
            begin
                gap_count  = '0;
                open_final = sample_idx;
            end
            else
            begin
                if (gap_count != GAP_MAX)
                    gap_count = gap_count + 1'b1;
                if (gap_count >= rollback)
                begin
                    close_now = 1'b1;
                    in_region = 1'b0;
                end
            end
        end
        else if (saturated)
        begin
            open_first = sample_idx;
            open_final = sample_idx;
            gap_count  = '0;
            in_region  = 1'b1;
        end
        if (last && in_region)
            close_now = 1'b1;
        if (close_now)
        begin
            span.span_first = open_first;
            span.span_last  = open_final;
            expected_regions.insert(expected_regions.size(), span);
        end
        if (last)
        begin
            in_region  = 1'b0;
            gap_count  = '0;
            sample_idx = '0;
        end
        else
            sample_idx = sample_idx + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        region_span_t want;
        if (!rst_n)
        begin
            thr_code   = CODE_BITS'(SAT_CODE_RESET);
            rollback   = ROLLBACK_RESET;
            in_region  = 1'b0;
            gap_count  = '0;
            open_first = '0;
            open_final = '0;
            sample_idx = '0;
            expected_regions.delete();
            errors  = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_en)
            begin
                case (srf_reg_idx_t'(cfg_index))
                    REG_SAT_CODE:     thr_code = cfg_data[CODE_BITS-1:0];
                    REG_MAX_ROLLBACK: rollback = cfg_data[GAP_BITS-1:0];
                    default: ;
                endcase
            end
            if (samples.valid && samples.ready)
                track_sample(samples.sample_code, samples.end_of_record);
            if (regions.valid && regions.ready)
            begin
                if (expected_regions.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected region: expected none, got %0d..%0d",
                             $time, regions.region_first, regions.region_final);
                end
                else
                begin
                    want = expected_regions.pop_front();
                    checked++;
                    if (regions.region_first !== want.span_first ||
                        regions.region_final !== want.span_last)
                    begin
                        errors++;
                        $display("%0t: region mismatch: expected %0d..%0d, got %0d..%0d",
                                 $time, want.span_first, want.span_last,
                                 regions.region_first, regions.region_final);
                    end
                end
            end
        end
        fail_count      <= errors;
        pending         <= expected_regions.size();
        regions_checked <= checked;
    end

endmodule

### verif/saturation_region_finder_core_test.sv
// ----------------------------------------------------------------------------
// saturation_region_finder_core_test
// drives records of adc samples into the saturation region finder under
// several threshold and rollback settings and idling patterns; a checker
// beside the block predicts each closed region and compares the reports
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module saturation_region_finder_core_test;
    import srf_pkg::*;

    localparam int INDEX_BITS        = 20;
    localparam int CODE_BITS         = 12;
    localparam int CODE_MAX          = (1 << CODE_BITS) - 1;
    localparam int NUM_SEGMENTS      = 8;
    localparam int ITEMS_PER_SEGMENT = 55;
    // result register plus skid entry, with margin
    localparam int SETTLE_CYCLES     = 4;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    srf_sample_if #(.CODE_BITS(CODE_BITS))   samples();
    srf_region_if #(.INDEX_BITS(INDEX_BITS)) regions();

    int fail_count;
    int pending;
    int regions_checked;

    // idling percentages for the sender and the region sink
    int sender_idle_pct;
    int sink_stall_pct;

    // register values currently programmed, used to shape the samples
    int cur_thr;
    int cur_rollback;

    int items_sent;
    int records_sent;
    int settings_written;

    saturation_region_finder_core #(
        .INDEX_BITS(INDEX_BITS),
        .CODE_BITS (CODE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .regions  (regions),
        .cfg_en   (cfg_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    srf_region_checker #(
        .INDEX_BITS(INDEX_BITS),
        .CODE_BITS (CODE_BITS)
    ) region_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (samples),
        .regions        (regions),
        .cfg_en         (cfg_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .regions_checked(regions_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // region sink: ready drawn fresh every cycle at the current stall rate
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            regions.ready <= 1'b0;
        else
            regions.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic set_idling(input int send_pct, input int stall_pct);
        sender_idle_pct <= send_pct;
        sink_stall_pct  <= stall_pct;
    endtask

    // one item on the sample channel; valid stays high after acceptance so
    // back-to-back items never drop it, and an idle gap lowers it first
    task automatic send_sample(input logic [CODE_BITS-1:0] code, input logic last);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        samples.valid         <= 1'b1;
        samples.sample_code   <= code;
        samples.end_of_record <= last;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        items_sent++;
        if (last)
            records_sent++;
    endtask

    // stop sending and wait until every predicted region has been taken,
    // then let the result register and skid entry settle
    task automatic drain_results();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers written back to back while the block is idle; the
    // threshold write carries random junk above bit 11 to check masking
    task automatic program_registers(input int thr, input int rollback);
        logic [CFG_DATA_BITS-1:0] word;
        drain_results();
        word = CFG_DATA_BITS'($urandom);
        word[CODE_BITS-1:0] = CODE_BITS'(thr);
        cfg_en    <= 1'b1;
        cfg_index <= REG_SAT_CODE;
        cfg_data  <= word;
        @(posedge clk);
        cfg_index <= REG_MAX_ROLLBACK;
        cfg_data  <= CFG_DATA_BITS'(rollback);
        @(posedge clk);
        cfg_en <= 1'b0;
        cur_thr      = thr;
        cur_rollback = rollback;
        settings_written++;
    endtask

    // code on the wanted side of the threshold, hugging it now and then;
    // one in ten is plain noise over the whole code range
    function automatic logic [CODE_BITS-1:0] pick_code(input bit want_sat);
        if ($urandom_range(9) == 0)
            return CODE_BITS'($urandom);
        if (want_sat || cur_thr == 0)
        begin
            if ($urandom_range(3) == 0)
                return CODE_BITS'(cur_thr);
            return CODE_BITS'($urandom_range(CODE_MAX, cur_thr));
        end
        if ($urandom_range(3) == 0)
            return CODE_BITS'(cur_thr - 1);
        return CODE_BITS'($urandom_range(cur_thr - 1, 0));
    endfunction

    // gap lengths cluster around the rollback so regions close just in time,
    // just too late, or get extended
    function automatic int pick_gap();
        int span;
        case ($urandom_range(3))
            0:       span = cur_rollback - 1;
            1:       span = cur_rollback;
            2:       span = cur_rollback + 1;
            default: span = $urandom_range(6, 1);
        endcase
        if (span < 1 || span > 40)
            span = $urandom_range(6, 1);
        return span;
    endfunction

    // one record of alternating saturated bursts and unsaturated gaps
    task automatic send_record(input int len);
        bit sat_run;
        int run;
        int k;
        sat_run = $urandom_range(1);
        run     = 0;
        for (k = 0; k < len; k++)
        begin
            if (run <= 0)
            begin
                sat_run = !sat_run;
                run     = sat_run ? $urandom_range(5, 1) : pick_gap();
            end
            send_sample(pick_code(sat_run), k == len - 1);
            run--;
        end
    endtask

    initial
    begin
        int seg;
        int seg_start;
        int k;
        bit paused;

        // every input known from time zero
        rst_n                 <= 1'b0;
        samples.valid         <= 1'b0;
        samples.sample_code   <= '0;
        samples.end_of_record <= 1'b0;
        cfg_en                <= 1'b0;
        cfg_index             <= REG_SAT_CODE;
        cfg_data              <= '0;
        set_idling(0, 0);
        cur_thr          = SAT_CODE_RESET;
        cur_rollback     = int'(ROLLBACK_RESET);
        items_sent       = 0;
        records_sent     = 0;
        settings_written = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset settings: threshold all ones, rollback 10
        // single-sample record that is saturated: region closed by end of record
        send_sample(12'hFFF, 1'b1);
        // single-sample record below threshold: nothing
        send_sample(12'h000, 1'b1);
        // one below threshold, then a two-sample region closed by ten quiet samples
        send_sample(12'hFFE, 1'b0);
        send_sample(12'hFFF, 1'b0);
        send_sample(12'hFFF, 1'b0);
        for (k = 0; k < 10; k++)
            send_sample(12'h000, 1'b0);
        // fresh region opened and closed on the record's last sample
        send_sample(12'hFFF, 1'b1);

        // zero rollback: the first quiet sample closes the region
        program_registers(12'h800, 0);
        send_sample(12'h7FF, 1'b0);
        send_sample(12'h800, 1'b0);
        send_sample(12'h7FF, 1'b0);
        send_sample(12'hFFF, 1'b1);

        // threshold zero: every code saturates; rollback 1 closes on eor too
        program_registers(0, 1);
        send_sample(12'h000, 1'b0);
        send_sample(12'h000, 1'b1);
        program_registers(1, 1);
        send_sample(12'h001, 1'b0);
        send_sample(12'h000, 1'b1);

        // largest rollback: quiet samples keep the region open, end of record closes it
        program_registers(CODE_MAX, 16'hFFFF);
        send_sample(12'hFFF, 1'b0);
        for (k = 0; k < 20; k++)
            send_sample(12'h5A5, 1'b0);
        send_sample(12'h000, 1'b1);

        // ---- random records, settings and idling change per segment
        for (seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            case (seg % 4)
                0:       set_idling(0, 0);
                1:       set_idling(81, 0);
                2:       set_idling(0, 81);
                default: set_idling(6, 6);
            endcase
            case (seg)
                0:       program_registers(12'h800, 0);
                1:       program_registers(CODE_MAX, 3);
                2:       program_registers(0, 1);
                3:       program_registers($urandom_range(CODE_MAX), 16'hFFFF);
                4:       program_registers(1, 2);
                5:       program_registers($urandom_range(CODE_MAX), $urandom_range(8));
                6:       program_registers(4000, 5);
                default: program_registers($urandom_range(CODE_MAX), 10);
            endcase
            seg_start = items_sent;
            paused    = 1'b0;
            while (items_sent - seg_start < ITEMS_PER_SEGMENT)
            begin
                // in even segments, hold off mid-segment until every region is out
                if (!paused && seg % 2 == 0 &&
                    items_sent - seg_start >= ITEMS_PER_SEGMENT / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                // short records and lone samples break up the well-formed ones
                if ($urandom_range(7) == 0)
                    send_record($urandom_range(2, 1));
                else
                    send_record($urandom_range(48, 3));
            end
        end

        drain_results();

        $display("run covered %0d samples in %0d records under %0d settings; %0d regions checked",
                 items_sent, records_sent, settings_written, regions_checked);
        $display("threshold 0 to max, rollback 0 to max, idling on neither, either and both sides");
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### saturation_region_finder_core.f
rtl/srf_pkg.sv
rtl/srf_if.sv
rtl/srf_region_tracker.sv
rtl/srf_out_stage.sv
rtl/saturation_region_finder_core.sv
rtl/srf_checker.sv
verif/srf_region_checker.sv
verif/saturation_region_finder_core_test.sv
